FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RDIV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rdiv assertion failed");

`define RDIV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rdiv assertion failed");

`else

`define RDIV_ASSERT(label, clk, rst_n, prop)

`define RDIV_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/rdiv_pkg.sv
package rdiv_pkg;

  localparam int DATA_W    = 16;
  localparam int WIDTH_DEF = 16;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rdiv_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } rdiv_cmd_t;

endpackage

FILE: rtl/rdiv_if.sv
interface rdiv_in_if;
  logic                       valid;
  logic                       ready;
  logic [rdiv_pkg::DATA_W-1:0] dividend;
  logic [rdiv_pkg::DATA_W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rdiv_out_if;
  logic                       valid;
  logic                       ready;
  logic [rdiv_pkg::DATA_W-1:0] quotient;
  logic [rdiv_pkg::DATA_W-1:0] remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

FILE: rtl/restoring_divider_unit.sv
// the input beat loads the operands, then WIDTH iterations; the last writes the output register
// a new input is taken only once the previous one is through, since the single
//   shift-subtract-restore unit does one quotient bit per cycle, except when the last step is held
// a finished result waits in the output register; a held result stalls only the last step
// reset: synchronous active-low rst_n clears the controller and output valid
`include "assert_macros.svh"

module restoring_divider_unit #(
  parameter int WIDTH = rdiv_pkg::WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rdiv_in_if.sink     in_ch,
  rdiv_out_if.source  out_ch
);

  rdiv_pkg::rdiv_cmd_t cmd;

  rdiv_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rdiv_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .dividend  (in_ch.dividend),
    .divisor   (in_ch.divisor),
    .quotient  (out_ch.quotient),
    .remainder (out_ch.remainder)
  );

  `RDIV_ASSERT(a_busy_blocks_input, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
  `RDIV_ASSERT(a_load_in_idle_only, clk, rst_n, cmd.load |-> !cmd.step)
  `RDIV_ASSERT(a_out_hold, clk, rst_n, (out_ch.valid && !out_ch.ready) |=> out_ch.valid)

endmodule

FILE: rtl/rdiv_datapath.sv
module rdiv_datapath #(
  parameter int WIDTH = rdiv_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  rdiv_pkg::rdiv_cmd_t         cmd,
  input  logic [rdiv_pkg::DATA_W-1:0] dividend,
  input  logic [rdiv_pkg::DATA_W-1:0] divisor,
  output logic [rdiv_pkg::DATA_W-1:0] quotient,
  output logic [rdiv_pkg::DATA_W-1:0] remainder
);

  // num_r holds dividend bits still to come in its top, quotient bits in its bottom
  logic [WIDTH-1:0] num_r, num_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] den_r;
  logic             zero_r;
  logic [rdiv_pkg::DATA_W-1:0] quo_out_r, rem_out_r;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           borrow;

  always_comb begin
    trial   = {rem_r, num_r[WIDTH-1]};
    diff    = trial - {1'b0, den_r};
    borrow  = diff[WIDTH];
    rem_nxt = borrow ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
    num_nxt = {num_r[WIDTH-2:0], ~borrow};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= WIDTH'(dividend);
      den_r  <= WIDTH'(divisor);
      zero_r <= (WIDTH'(divisor) == '0);
      rem_r  <= '0;
    end else if (cmd.step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      quo_out_r <= zero_r ? '0 : rdiv_pkg::DATA_W'(num_nxt);
      rem_out_r <= zero_r ? '0 : rdiv_pkg::DATA_W'(rem_nxt);
    end
  end

  assign quotient  = quo_out_r;
  assign remainder = rem_out_r;

endmodule

FILE: rtl/rdiv_ctrl.sv
`include "assert_macros.svh"

module rdiv_ctrl #(
  parameter int WIDTH = rdiv_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rdiv_pkg::rdiv_cmd_t cmd
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  rdiv_pkg::rdiv_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdiv_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_free     = !out_valid_r || out_ready;
    last         = (cnt_r == CNT_W'(1));
    case (state_r)
      rdiv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(WIDTH);
          state_nxt = rdiv_pkg::ST_RUN;
        end
      end
      rdiv_pkg::ST_RUN: begin
        if (!last) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end else if (out_free) begin
          // final step lands straight in the output register
          cmd.step     = 1'b1;
          cmd.out_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = rdiv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rdiv_pkg::ST_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `RDIV_ASSERT(a_accept_runs, clk, rst_n, (in_valid && in_ready) |=> (state_r == rdiv_pkg::ST_RUN))
  `RDIV_ASSERT(a_run_count, clk, rst_n, (state_r == rdiv_pkg::ST_RUN) |-> (cnt_r != '0))
  `RDIV_ASSERT(a_no_overwrite, clk, rst_n, cmd.out_load |-> (!out_valid_r || out_ready))
  `RDIV_ASSERT(a_load_sets_valid, clk, rst_n, cmd.out_load |=> out_valid)

endmodule

FILE: verif/restoring_divider_unit_tb.sv
`timescale 1ns / 100ps

module restoring_divider_unit_tb;

  localparam int DUT_W      = rdiv_pkg::WIDTH_DEF;
  localparam int DATA_W     = rdiv_pkg::DATA_W;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 2 * (DUT_W + 1) + 8;
  localparam int N_RANDOM   = 1950;

  typedef struct {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    int                gap;
  } div_job_t;

  typedef struct {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } quot_rem_t;

  logic clk = 1'b0;
  logic rst_n;

  rdiv_in_if  in_ch ();
  rdiv_out_if out_ch ();

  restoring_divider_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  div_job_t  div_jobs[$];
  quot_rem_t quot_rem_due[$];

  int  errors      = 0;
  int  n_in        = 0;
  int  n_out       = 0;
  int  n_zero_den  = 0;
  int  idle_cycles = 0;
  logic in_taken   = 1'b0;
  logic in_loaded  = 1'b0;
  int  in_gap      = 0;
  int  out_hold    = 0;
  int  out_free    = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = DATA_W'($urandom_range(0, 15));
      1: v = {DATA_W{1'b1}} - DATA_W'($urandom_range(0, 15));
      2: v = DATA_W'($urandom() >> $urandom_range(0, 31));
      default: v = DATA_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic quot_rem_t predict_quot_rem(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
    logic [63:0] wmask, span, n, d, part, diff, q;
    quot_rem_t   res;
    wmask = (64'd1 << DUT_W) - 64'd1;
    span  = (64'd1 << (DUT_W + 1)) - 64'd1;
    n     = 64'(num) & wmask;
    d     = 64'(den) & wmask;
    part  = '0;
    q     = '0;
    res.dividend  = num;
    res.divisor   = den;
    res.quotient  = '0;
    res.remainder = '0;
    if (d != 64'd0) begin
      for (int i = DUT_W - 1; i >= 0; i--) begin
        part = ((part << 1) | ((n >> i) & 64'd1)) & span;
        diff = (part - d) & span;
        // top bit of the widened difference is the borrow
        if (!diff[DUT_W]) begin
          part = diff;
          q[i] = 1'b1;
        end
      end
      res.quotient  = q[DATA_W-1:0];
      res.remainder = part[DATA_W-1:0] & wmask[DATA_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 40) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task automatic add_job(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den, int gap);
    div_job_t j;
    j.dividend = num;
    j.divisor  = den;
    j.gap      = gap;
    div_jobs.push_back(j);
  endtask

  // input driver
  always @(negedge clk) begin
    div_job_t j;
    if (rst_n) begin
      if (in_taken) in_loaded = 1'b0;
      if (!in_loaded && div_jobs.size() > 0) begin
        if (in_gap < div_jobs[0].gap) begin
          in_gap++;
        end else begin
          j = div_jobs.pop_front();
          in_gap = 0;
          in_loaded = 1'b1;
          in_ch.dividend <= j.dividend;
          in_ch.divisor  <= j.divisor;
        end
      end
      in_ch.valid <= in_loaded;
    end
  end

  // result-side back pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_free > 0) out_free--;
        else if ($urandom_range(0, 199) == 0) out_free = $urandom_range(50, 300);
        else if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    quot_rem_t want;
    logic in_beat, out_beat;
    in_beat  = in_ch.valid && in_ch.ready;
    out_beat = out_ch.valid && out_ch.ready;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_beat;
      if (in_beat) begin
        n_in++;
        if (in_ch.divisor == '0) n_zero_den++;
        quot_rem_due.push_back(predict_quot_rem(in_ch.dividend, in_ch.divisor));
      end
      if (out_beat) begin
        n_out++;
        if (quot_rem_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending q=%h r=%h",
                                    out_ch.quotient, out_ch.remainder));
        end else begin
          want = quot_rem_due.pop_front();
          if (out_ch.quotient !== want.quotient)
            report_mismatch($sformatf("%h / %h quotient %h want %h", want.dividend,
                                      want.divisor, out_ch.quotient, want.quotient));
          if (out_ch.remainder !== want.remainder)
            report_mismatch($sformatf("%h / %h remainder %h want %h", want.dividend,
                                      want.divisor, out_ch.remainder, want.remainder));
        end
      end
      if (in_beat || out_beat) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 IDLE_LIMIT, quot_rem_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] num, den;
    int calm;
    int gap;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    out_ch.ready   = 1'b0;

    // directed corners: zero operands, all ones, msb patterns, divisor above dividend
    add_job(16'h0000, 16'h0000, 0);
    add_job(16'h0000, 16'h0001, 0);
    add_job(16'h0001, 16'h0000, 1);
    add_job(16'hffff, 16'h0000, 0);
    add_job(16'hffff, 16'h0001, 0);
    add_job(16'hffff, 16'hffff, 2);
    add_job(16'h0000, 16'hffff, 0);
    add_job(16'h0001, 16'hffff, 0);
    add_job(16'hfffe, 16'hffff, 0);
    add_job(16'hffff, 16'hfffe, 5);
    add_job(16'h8000, 16'h8000, 0);
    add_job(16'h7fff, 16'h8000, 0);
    add_job(16'h8000, 16'h7fff, 0);
    add_job(16'hffff, 16'h8000, 0);
    add_job(16'h8000, 16'h0001, 3);
    add_job(16'hffff, 16'h0002, 0);
    add_job(16'haaaa, 16'h5555, 0);
    add_job(16'h5555, 16'haaaa, 0);
    add_job(16'h0100, 16'h0003, 0);
    add_job(16'hffff, 16'h0100, 0);
    add_job(16'h0001, 16'h0001, 0);
    add_job(16'h0007, 16'h0007, 0);
    add_job(16'h1234, 16'h0001, 0);

    calm = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (calm > 0) calm--;
      else if ($urandom_range(0, 149) == 0) calm = $urandom_range(40, 120);
      num = rand_operand();
      case ($urandom_range(0, 19))
        0:       den = '0;
        1, 2:    den = num + DATA_W'($urandom_range(0, 3)) - DATA_W'(1);
        3:       den = DATA_W'($urandom_range(1, 15));
        default: den = rand_operand();
      endcase
      gap = (calm > 0) ? 0 : pick_gap();
      add_job(num, den, gap);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (div_jobs.size() > 0 || in_loaded || quot_rem_due.size() > 0) @(posedge clk);
    // stray results after the last one expected still get caught by the monitor
    repeat (DRAIN_CYC) @(posedge clk);

    $display("divided %0d operand pairs (%0d by zero), checked %0d results, %0d mismatches",
             n_in, n_zero_den, n_out, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
